>>> hdl/trvm_pkg.sv
// trvm_pkg: shared types and constants for the tiny register vm execute block
// no dependencies; used by the interfaces, the iterative unit and the top level
`timescale 1ns / 1ps

package trvm_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValueW   = 17;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned ProductW = 2 * ByteW;
  localparam int unsigned NumRegsDefault = 4;

  // instruction codes; every code from OpCount upward is illegal
  typedef enum logic [ByteW-1:0] {
    OP_ADD = 8'd0,
    OP_SUB = 8'd1,
    OP_MUL = 8'd2,
    OP_DIV = 8'd3,
    OP_MOD = 8'd4,
    OP_STP = 8'd5,
    OP_LDI = 8'd6,
    OP_ADR = 8'd7,
    OP_SUR = 8'd8,
    OP_INC = 8'd9,
    OP_DEC = 8'd10
  } trvm_op_e;

  localparam logic [ByteW-1:0] OpCount   = 8'd11;
  localparam logic [ByteW-1:0] OpFirstReg = 8'd6;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 3'd0,
    ST_DIV0   = 3'd1,
    ST_BADREG = 3'd2,
    ST_BADOP  = 3'd3,
    ST_STOP   = 3'd4,
    ST_HALTED = 3'd5
  } trvm_status_e;

  typedef enum logic [1:0] {
    UNIT_MUL = 2'd0,
    UNIT_DIV = 2'd1,
    UNIT_MOD = 2'd2
  } trvm_unit_mode_e;

  typedef struct packed {
    logic            start;
    trvm_unit_mode_e mode;
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
  } trvm_unit_cmd_t;

  typedef struct packed {
    logic                last;
    logic [ProductW-1:0] result;
  } trvm_unit_rsp_t;

endpackage

>>> hdl/trvm_instr_if.sv
// trvm_instr_if: instruction channel, valid/ready handshake with three byte payload
// depends on trvm_pkg
`timescale 1ns / 1ps

interface trvm_instr_if
  import trvm_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] opcode;
  logic [ByteW-1:0] left_byte;
  logic [ByteW-1:0] right_byte;

  modport source (output valid, output opcode, output left_byte, output right_byte,
                  input ready);
  modport sink   (input valid, input opcode, input left_byte, input right_byte,
                  output ready);

endinterface

>>> hdl/trvm_result_if.sv
// trvm_result_if: result channel, valid/ready handshake with value and status
// depends on trvm_pkg
`timescale 1ns / 1ps

interface trvm_result_if
  import trvm_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;
  logic [StatusW-1:0]       status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);

endinterface

>>> hdl/trvm_seq_unit.sv
// trvm_seq_unit: shared 9-bit adder stepped eight times, shift-add multiply
// and restoring divide; depends on trvm_pkg
`timescale 1ns / 1ps

module trvm_seq_unit
  import trvm_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  trvm_unit_cmd_t cmd_i,
  output trvm_unit_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(ByteW);
  localparam logic [CntW-1:0] LastStep = CntW'(ByteW - 1);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  trvm_unit_mode_e  mode_q;
  logic [ByteW-1:0] hi_q, hi_d;
  logic [ByteW-1:0] lo_q, lo_d;
  logic [ByteW-1:0] b_q;

  logic [ByteW:0]   op_a, op_b;
  logic             cin;
  logic [ByteW+1:0] sum;

  // one adder: hi + (lo lsb ? b : 0) for multiply, {hi, lo msb} - b for divide
  always_comb begin
    if (mode_q == UNIT_MUL) begin
      op_a = {1'b0, hi_q};
      op_b = {1'b0, (lo_q[0] ? b_q : '0)};
      cin  = 1'b0;
    end else begin
      op_a = {hi_q, lo_q[ByteW-1]};
      op_b = ~{1'b0, b_q};
      cin  = 1'b1;
    end
    sum = {1'b0, op_a} + {1'b0, op_b} + {{(ByteW+1){1'b0}}, cin};

    if (mode_q == UNIT_MUL) begin
      hi_d = sum[ByteW:1];
      lo_d = {sum[0], lo_q[ByteW-1:1]};
    end else begin
      // carry out means no borrow: trial subtract succeeded
      hi_d = sum[ByteW+1] ? sum[ByteW-1:0] : op_a[ByteW-1:0];
      lo_d = {lo_q[ByteW-2:0], sum[ByteW+1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= UNIT_MUL;
      hi_q   <= '0;
      lo_q   <= '0;
      b_q    <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      mode_q <= cmd_i.mode;
      hi_q   <= '0;
      lo_q   <= cmd_i.a;
      b_q    <= cmd_i.b;
    end else if (busy_q) begin
      hi_q  <= hi_d;
      lo_q  <= lo_d;
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp_o.last = busy_q && (cnt_q == LastStep);
    unique case (mode_q)
      UNIT_MUL: rsp_o.result = {hi_q, lo_q};
      UNIT_DIV: rsp_o.result = {{ByteW{1'b0}}, lo_q};
      UNIT_MOD: rsp_o.result = {{ByteW{1'b0}}, hi_q};
      default:  rsp_o.result = '0;
    endcase
  end

endmodule

>>> hdl/tiny_register_vm_execute.sv
// tiny_register_vm_execute: top level, decode, register file and result register
// depends on trvm_pkg, trvm_instr_if, trvm_result_if and trvm_seq_unit
`timescale 1ns / 1ps

// usage
// - instr_i carries one instruction per transaction: opcode, left_byte, right_byte
// - result_o returns exactly one transaction per instruction: value and status
// - add, sub, stp, ldi, adr, sur, inc, dec and every error case finish at the
//   accepting edge; the result is visible the next cycle, so one instruction per
//   cycle is sustained while the receiver keeps up
// - mul, div and mod run on one shared 9-bit adder stepped eight times (shift-add
//   or restoring divide): the unit steps in S_ITER, then S_WAIT loads the result
//   register once it is free; no new instruction is taken until back in S_IDLE
// - div or mod by zero bypasses the shared unit and finishes at once
// - the result register decouples the two sides: a new instruction is taken
//   while a finished result waits, as long as the register frees at that edge
// - when the receiver stalls, the result is held stable and instr_i.ready drops
//   until the result register can accept the next result
// - reset clears the register file to zero, clears the halt flag and empties the
//   result register; after stp, a bad register or a bad opcode every later
//   instruction reports already halted until the next reset

module tiny_register_vm_execute
  import trvm_pkg::*;
#(
  parameter int unsigned NUM_REGS = NumRegsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  trvm_instr_if.sink    instr_i,
  trvm_result_if.source result_o
);

  localparam int unsigned IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam logic [ByteW-1:0] NumRegsB = ByteW'(NUM_REGS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ITER,
    S_WAIT
  } state_e;

  state_e state_q;

  logic [ByteW-1:0]         regs_q [NUM_REGS];
  logic                     halted_q;
  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_value_q;
  trvm_status_e             out_status_q;

  trvm_unit_cmd_t unit_cmd;
  trvm_unit_rsp_t unit_rsp;

  // decode results
  logic                     accept;
  logic                     out_free;
  logic                     use_unit;
  trvm_unit_mode_e          unit_mode;
  logic                     halt_set;
  logic                     wr_en;
  logic signed [ValueW-1:0] imm_value;
  trvm_status_e             imm_status;
  logic [ByteW-1:0]         rv;
  logic [ValueW-1:0]        l_ext, r_ext, rv_ext;

  // output slot is free if empty or being drained this cycle
  assign out_free      = !out_valid_q || result_o.ready;
  assign instr_i.ready = (state_q == S_IDLE) && out_free;
  assign accept        = instr_i.valid && instr_i.ready;

  assign rv     = regs_q[instr_i.left_byte[IdxW-1:0]];
  assign l_ext  = {{(ValueW-ByteW){1'b0}}, instr_i.left_byte};
  assign r_ext  = {{(ValueW-ByteW){1'b0}}, instr_i.right_byte};
  assign rv_ext = {{(ValueW-ByteW){1'b0}}, rv};

  always_comb begin
    use_unit   = 1'b0;
    unit_mode  = UNIT_MUL;
    halt_set   = 1'b0;
    wr_en      = 1'b0;
    imm_value  = '0;
    imm_status = ST_OK;

    if (halted_q) begin
      imm_status = ST_HALTED;
    end else if (instr_i.opcode >= OpCount) begin
      imm_status = ST_BADOP;
      halt_set   = 1'b1;
    end else if ((instr_i.opcode >= OpFirstReg) && (instr_i.left_byte >= NumRegsB)) begin
      imm_status = ST_BADREG;
      halt_set   = 1'b1;
    end else begin
      unique case (trvm_op_e'(instr_i.opcode))
        OP_ADD: imm_value = l_ext + r_ext;
        OP_SUB: imm_value = l_ext - r_ext;
        OP_MUL: begin
          use_unit  = 1'b1;
          unit_mode = UNIT_MUL;
        end
        OP_DIV, OP_MOD: begin
          // zero divisor short-cuts both div and mod
          if (instr_i.right_byte == '0) begin
            imm_status = ST_DIV0;
          end else begin
            use_unit  = 1'b1;
            unit_mode = (trvm_op_e'(instr_i.opcode) == OP_DIV) ? UNIT_DIV : UNIT_MOD;
          end
        end
        OP_STP: begin
          imm_value  = l_ext;
          imm_status = ST_STOP;
          halt_set   = 1'b1;
        end
        OP_LDI: begin
          imm_value = r_ext;
          wr_en     = 1'b1;
        end
        OP_ADR: imm_value = rv_ext + r_ext;
        OP_SUR: imm_value = rv_ext - r_ext;
        OP_INC: imm_value = {{(ValueW-ByteW){1'b0}}, rv + 1'b1};
        OP_DEC: imm_value = {{(ValueW-ByteW){1'b0}}, rv - 1'b1};
        default: imm_status = ST_BADOP;
      endcase
    end
  end

  assign unit_cmd.start = accept && use_unit;
  assign unit_cmd.mode  = unit_mode;
  assign unit_cmd.a     = instr_i.left_byte;
  assign unit_cmd.b     = instr_i.right_byte;

  trvm_seq_unit u_seq_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (unit_cmd),
    .rsp_o  (unit_rsp)
  );

  // sequencer, architectural state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      halted_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= ST_OK;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (halt_set) begin
              halted_q <= 1'b1;
            end
            if (wr_en) begin
              regs_q[instr_i.left_byte[IdxW-1:0]] <= instr_i.right_byte;
            end
            if (use_unit) begin
              state_q <= S_ITER;
              if (result_o.ready) begin
                out_valid_q <= 1'b0;
              end
            end else begin
              out_valid_q  <= 1'b1;
              out_value_q  <= imm_value;
              out_status_q <= imm_status;
            end
          end else if (result_o.ready) begin
            out_valid_q <= 1'b0;
          end
        end
        S_ITER: begin
          if (unit_rsp.last) begin
            state_q <= S_WAIT;
          end
          if (result_o.ready) begin
            out_valid_q <= 1'b0;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            state_q      <= S_IDLE;
            out_valid_q  <= 1'b1;
            out_value_q  <= {1'b0, unit_rsp.result};
            out_status_q <= ST_OK;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid  = out_valid_q;
  assign result_o.value  = out_value_q;
  assign result_o.status = out_status_q;

endmodule
